// ===== src/fpr_pkg.sv =====
package fpr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;

  localparam int CFG_W   = 5;
  localparam int TOTAL_W = 16;
  localparam int RES_W   = 5;
  localparam int NF_W    = $clog2(MAX_FRAMES + 1);

  localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(3);
  localparam logic [TOTAL_W-1:0] COUNTER_MAX  = '1;

  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] page;
  } frame_t;

  typedef frame_t [MAX_FRAMES-1:0] frame_row_t;

  localparam int ROW_W = $bits(frame_row_t);

  typedef struct packed {
    logic                 fault;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [TOTAL_W-1:0]   fault_total;
    logic [RES_W-1:0]     resident_count;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } state_t;

endpackage

// ===== src/fpr_ifs.sv =====
interface fpr_ref_if;
  logic                          valid;
  logic                          ready;
  logic [fpr_pkg::PAGE_BITS-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface fpr_res_if;
  logic                          valid;
  logic                          ready;
  logic                          fault;
  logic                          evicted_valid;
  logic [fpr_pkg::PAGE_BITS-1:0] evicted_page;
  logic [fpr_pkg::TOTAL_W-1:0]   fault_total;
  logic [fpr_pkg::RES_W-1:0]     resident_count;

  modport source (output valid, output fault, output evicted_valid, output evicted_page,
                  output fault_total, output resident_count, input ready);
  modport sink   (input valid, input fault, input evicted_valid, input evicted_page,
                  input fault_total, input resident_count, output ready);
endinterface

// ===== src/fpr_ram.sv =====
module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/fpr_update.sv =====
module fpr_update (
  input  fpr_pkg::frame_row_t              row,
  input  logic [fpr_pkg::PAGE_BITS-1:0]    page,
  input  logic [fpr_pkg::CFG_W-1:0]        frames_in_use,
  input  logic [fpr_pkg::TOTAL_W-1:0]      fault_count,
  output fpr_pkg::frame_row_t              row_next,
  output logic [fpr_pkg::TOTAL_W-1:0]      fault_count_next,
  output fpr_pkg::result_t                 result
);
  import fpr_pkg::*;

  logic [NF_W-1:0]  nf;
  logic             hit;
  logic [NF_W-1:0]  resident;

  // clamp window to 1..MAX_FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      nf = NF_W'(1);
    end else if (int'(frames_in_use) > MAX_FRAMES) begin
      nf = NF_W'(MAX_FRAMES);
    end else begin
      nf = NF_W'(frames_in_use);
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < MAX_FRAMES; k++) begin
      if (k < int'(nf) && row[k].valid && row[k].page == page) begin
        hit = 1'b1;
      end
    end
  end

  // on a miss the window shifts toward slot 0 and the new page lands on top
  always_comb begin
    row_next = row;
    if (!hit) begin
      for (int k = 0; k < MAX_FRAMES - 1; k++) begin
        if (k + 1 < int'(nf)) begin
          row_next[k] = row[k+1];
        end
      end
      for (int k = 0; k < MAX_FRAMES; k++) begin
        if (k + 1 == int'(nf)) begin
          row_next[k].valid = 1'b1;
          row_next[k].page  = page;
        end
      end
    end
  end

  always_comb begin
    resident = '0;
    for (int k = 0; k < MAX_FRAMES; k++) begin
      if (k < int'(nf) && row_next[k].valid) begin
        resident = resident + NF_W'(1);
      end
    end
  end

  always_comb begin
    fault_count_next = fault_count;
    if (!hit && fault_count != COUNTER_MAX) begin
      fault_count_next = fault_count + TOTAL_W'(1);
    end
  end

  always_comb begin
    result.fault          = !hit;
    result.evicted_valid  = !hit && row[0].valid;
    result.evicted_page   = (!hit && row[0].valid) ? row[0].page : '0;
    result.fault_total    = fault_count_next;
    result.resident_count = RES_W'(resident);
  end

endmodule

// ===== src/fifo_page_replacement.sv =====
// channel  | dir | handshake           | payload
// refs     | in  | refs.valid/ready    | page
// results  | out | results.valid/ready | fault, evicted_valid, evicted_page,
//          |     |                     |   fault_total, resident_count
// cfg      | in  | cfg_we              | cfg_wdata (frames_in_use)
//
// The frame row is read from the state RAM on accept, then compared, shifted
// and written back in the compute state when the result register is loaded.
// No clearing pass: a row-loaded flag makes the row read as all-empty until
// the first write-back. Reset sets frames_in_use to 3.
// A full result register holds the item in the compute state; refs.ready
// stays low until the result is loaded.
module fifo_page_replacement (
  input  logic                        clk,
  input  logic                        rst,
  fpr_ref_if.sink                     refs,
  fpr_res_if.source                   results,
  input  logic                        cfg_we,
  input  logic [fpr_pkg::CFG_W-1:0]   cfg_wdata
);
  import fpr_pkg::*;

  state_t               state;
  logic [CFG_W-1:0]     frames_in_use;
  logic [TOTAL_W-1:0]   fault_count;
  logic [TOTAL_W-1:0]   fault_count_next;
  logic [PAGE_BITS-1:0] page_q;
  logic                 row_loaded;
  logic [ROW_W-1:0]     ram_rdata;
  frame_row_t           row_cur;
  frame_row_t           row_next;
  result_t              result;
  result_t              out_q;
  logic                 out_valid;
  logic                 accept;
  logic                 load;

  assign refs.ready = (state == S_IDLE);
  assign accept     = refs.valid && refs.ready;
  assign load       = (state == S_CALC) && (!out_valid || results.ready);
  assign row_cur    = row_loaded ? frame_row_t'(ram_rdata) : '0;

  fpr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (1)
  ) u_ram (
    .clk   (clk),
    .we    (load),
    .waddr (1'b0),
    .wdata (ROW_W'(row_next)),
    .re    (accept),
    .raddr (1'b0),
    .rdata (ram_rdata)
  );

  fpr_update u_update (
    .row              (row_cur),
    .page             (page_q),
    .frames_in_use    (frames_in_use),
    .fault_count      (fault_count),
    .row_next         (row_next),
    .fault_count_next (fault_count_next),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frames_in_use <= FRAMES_RESET;
      fault_count   <= '0;
      row_loaded    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        frames_in_use <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (load) begin
        fault_count <= fault_count_next;
        row_loaded  <= 1'b1;
        out_valid   <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page_q <= refs.page;
    end
    if (load) begin
      out_q <= result;
    end
  end

  assign results.valid          = out_valid;
  assign results.fault          = out_q.fault;
  assign results.evicted_valid  = out_q.evicted_valid;
  assign results.evicted_page   = out_q.evicted_page;
  assign results.fault_total    = out_q.fault_total;
  assign results.resident_count = out_q.resident_count;

endmodule
